/* hdl/ccir_pkg.sv */
`default_nettype none

package ccir_pkg;

   localparam int COORD_W   = 24;
   localparam int MASS_W    = 16;
   localparam int ELAST_W   = 9;
   localparam int DIFF_W    = 25;
   localparam int SQ_IN_W   = 50;
   localparam int SQ_OUT_W  = 25;
   localparam int SQ_REM_W  = 27;
   localparam int NORM_BITS = 16;
   localparam int NORM_W    = 18;
   localparam int PROD_W    = 43;
   localparam int VN_W      = 28;
   localparam int NEG_VN_W  = 26;
   localparam int RAD_W     = 21;
   localparam int OVL_W     = 27;
   localparam int MSUM_W    = 17;
   localparam int S_W       = 35;
   localparam int DIV_Q_W   = 35;
   localparam int DV_SHIFT  = 24;
   localparam int DV_W      = 30;
   localparam int CORR_SHIFT = 17;
   localparam int CORR_W    = 23;
   localparam int SUM_W     = 31;

   localparam logic [ELAST_W-1:0] ELAST_RESET = 9'd205;
   localparam logic [ELAST_W:0]   ELAST_ONE   = 10'd256;

   localparam logic [1:0] OUTCOME_COINCIDE = 2'd0;
   localparam logic [1:0] OUTCOME_SEPARATE = 2'd1;
   localparam logic [1:0] OUTCOME_IMPULSE  = 2'd2;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [NORM_W-1:0]  norm_type;

   typedef struct packed {
      coord_type           p1x;
      coord_type           p1y;
      coord_type           v1x;
      coord_type           v1y;
      coord_type           p2x;
      coord_type           p2y;
      coord_type           v2x;
      coord_type           v2y;
      logic [MASS_W-1:0]   m1;
      logic [MASS_W-1:0]   m2;
   } pair_type;

   function automatic coord_type sat_coord(input logic signed [SUM_W-1:0] v);
      coord_type r;
      if (!v[SUM_W-1] && (|v[SUM_W-2:COORD_W-1])) begin
         r = {1'b0, {(COORD_W-1){1'b1}}};
      end else if (v[SUM_W-1] && !(&v[SUM_W-2:COORD_W-1])) begin
         r = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* hdl/circle_collision_impulse_resolve_top.sv */
`default_nettype none

// Resolves one pair of circles per clock: start with busy low transfers a pair, and
// its result appears for exactly one cycle with rsp_strobe high. Each pair passes
// through the 25-stage square root, the 17-stage normal divider and the
// 35-stage impulse and push-out dividers, all fully pipelined, so busy never rises
// and pairs may enter in every cycle. The receiver cannot stall: sample each result
// in its strobe cycle. Write elasticity only while no pair is in flight.

module circle_collision_impulse_resolve_top
   import ccir_pkg::*;
#(
   parameter int FRACTION_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      csr_wr_en,
   input  logic [ELAST_W-1:0]        csr_wr_data,
   input  logic signed [COORD_W-1:0] req_first_pos_x,
   input  logic signed [COORD_W-1:0] req_first_pos_y,
   input  logic signed [COORD_W-1:0] req_first_vel_x,
   input  logic signed [COORD_W-1:0] req_first_vel_y,
   input  logic [MASS_W-1:0]         req_first_mass,
   input  logic signed [COORD_W-1:0] req_second_pos_x,
   input  logic signed [COORD_W-1:0] req_second_pos_y,
   input  logic signed [COORD_W-1:0] req_second_vel_x,
   input  logic signed [COORD_W-1:0] req_second_vel_y,
   input  logic [MASS_W-1:0]         req_second_mass,
   output logic                      rsp_strobe,
   output logic signed [COORD_W-1:0] rsp_new_first_pos_x,
   output logic signed [COORD_W-1:0] rsp_new_first_pos_y,
   output logic signed [COORD_W-1:0] rsp_new_first_vel_x,
   output logic signed [COORD_W-1:0] rsp_new_first_vel_y,
   output logic signed [COORD_W-1:0] rsp_new_second_pos_x,
   output logic signed [COORD_W-1:0] rsp_new_second_pos_y,
   output logic signed [COORD_W-1:0] rsp_new_second_vel_x,
   output logic signed [COORD_W-1:0] rsp_new_second_vel_y,
   output logic [1:0]                rsp_outcome
);

   localparam logic [RAD_W-1:0] RAD_BASE = RAD_W'(5 << (FRACTION_BITS + 1));
   localparam int NX_NUM_W = DIFF_W + NORM_BITS;
   localparam int Q_NUM_W  = S_W + MASS_W;
   localparam int A_NUM_W  = 2 * RAD_W;

   typedef struct packed {
      pair_type                  pair;
      logic signed [DIFF_W-1:0]  dx;
      logic signed [DIFF_W-1:0]  dy;
   } sq_tag_type;

   typedef struct packed {
      pair_type              pair;
      logic                  sx;
      logic [SQ_OUT_W-1:0]   span;
   } nx_tag_type;

   typedef struct packed {
      pair_type           pair;
      norm_type           nx;
      norm_type           ny;
      logic [1:0]         outcome;
      logic               ov_pos;
      logic [S_W-1:0]     s;
      logic [RAD_W-1:0]   ov;
   } ap_tag_type;

   logic [ELAST_W-1:0] elast_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         elast_ff <= ELAST_RESET;
      end else if (csr_wr_en) begin
         elast_ff <= csr_wr_data;
      end
   end

   assign busy = 1'b0;

   // stage a: capture and differences
   pair_type                 pair_in;
   logic                     valid_a_ff;
   pair_type                 pair_a_ff;
   logic signed [DIFF_W-1:0] dx_a_ff, dy_a_ff;

   always_comb begin
      pair_in.p1x = req_first_pos_x;
      pair_in.p1y = req_first_pos_y;
      pair_in.v1x = req_first_vel_x;
      pair_in.v1y = req_first_vel_y;
      pair_in.m1  = req_first_mass;
      pair_in.p2x = req_second_pos_x;
      pair_in.p2y = req_second_pos_y;
      pair_in.v2x = req_second_vel_x;
      pair_in.v2y = req_second_vel_y;
      pair_in.m2  = req_second_mass;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= start && !busy;
      end
      pair_a_ff <= pair_in;
      dx_a_ff   <= {req_first_pos_x[COORD_W-1], req_first_pos_x}
                 - {req_second_pos_x[COORD_W-1], req_second_pos_x};
      dy_a_ff   <= {req_first_pos_y[COORD_W-1], req_first_pos_y}
                 - {req_second_pos_y[COORD_W-1], req_second_pos_y};
   end

   // stage b: squares
   logic                     valid_b_ff;
   pair_type                 pair_b_ff;
   logic signed [DIFF_W-1:0] dx_b_ff, dy_b_ff;
   logic [SQ_IN_W-1:0]       sqx_b_ff, sqy_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else begin
         valid_b_ff <= valid_a_ff;
      end
      pair_b_ff <= pair_a_ff;
      dx_b_ff   <= dx_a_ff;
      dy_b_ff   <= dy_a_ff;
      sqx_b_ff  <= dx_a_ff * dx_a_ff;
      sqy_b_ff  <= dy_a_ff * dy_a_ff;
   end

   // stage c: squared distance
   logic               valid_c_ff;
   sq_tag_type         sq_tag_c_ff;
   logic [SQ_IN_W-1:0] d2_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_c_ff <= 1'b0;
      end else begin
         valid_c_ff <= valid_b_ff;
      end
      sq_tag_c_ff.pair <= pair_b_ff;
      sq_tag_c_ff.dx   <= dx_b_ff;
      sq_tag_c_ff.dy   <= dy_b_ff;
      d2_c_ff          <= sqx_b_ff + sqy_b_ff;
   end

   logic                sq_valid;
   logic [SQ_OUT_W-1:0] sq_root;
   sq_tag_type          sq_tag;

   ccir_sqrt #(
      .TAG_W($bits(sq_tag_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_c_ff),
      .in_value  (d2_c_ff),
      .in_tag    (sq_tag_c_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_tag   (sq_tag)
   );

   logic [DIFF_W-1:0] dx_abs, dy_abs;
   nx_tag_type        nx_tag_in;

   assign dx_abs = sq_tag.dx[DIFF_W-1] ? DIFF_W'(-sq_tag.dx) : DIFF_W'(sq_tag.dx);
   assign dy_abs = sq_tag.dy[DIFF_W-1] ? DIFF_W'(-sq_tag.dy) : DIFF_W'(sq_tag.dy);

   always_comb begin
      nx_tag_in.pair = sq_tag.pair;
      nx_tag_in.sx   = sq_tag.dx[DIFF_W-1];
      nx_tag_in.span = sq_root;
   end

   logic                nd_valid;
   logic [NORM_W-2:0]   nd_quo_x, nd_quo_y;
   nx_tag_type          nd_tag;
   logic                nd_sy;

   ccir_div #(
      .NUM_W (NX_NUM_W),
      .DEN_W (SQ_OUT_W),
      .QUO_W (NORM_W - 1),
      .TAG_W ($bits(nx_tag_type))
   ) u_div_nx (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (sq_valid),
      .in_num     ({dx_abs, {NORM_BITS{1'b0}}}),
      .in_den     (sq_root),
      .in_tag     (nx_tag_in),
      .out_valid  (nd_valid),
      .out_quo    (nd_quo_x),
      .out_rem_nz (),
      .out_tag    (nd_tag)
   );

   ccir_div #(
      .NUM_W (NX_NUM_W),
      .DEN_W (SQ_OUT_W),
      .QUO_W (NORM_W - 1),
      .TAG_W (1)
   ) u_div_ny (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (sq_valid),
      .in_num     ({dy_abs, {NORM_BITS{1'b0}}}),
      .in_den     (sq_root),
      .in_tag     (sq_tag.dy[DIFF_W-1]),
      .out_valid  (),
      .out_quo    (nd_quo_y),
      .out_rem_nz (),
      .out_tag    (nd_sy)
   );

   // stage d: signed normal, relative velocity
   logic                     valid_d_ff;
   pair_type                 pair_d_ff;
   norm_type                 nx_d_ff, ny_d_ff;
   logic signed [DIFF_W-1:0] rvx_d_ff, rvy_d_ff;
   logic                     zero_d_ff;
   logic [SQ_OUT_W-1:0]      dist_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_d_ff <= 1'b0;
      end else begin
         valid_d_ff <= nd_valid;
      end
      pair_d_ff <= nd_tag.pair;
      nx_d_ff   <= nd_tag.sx ? -$signed({1'b0, nd_quo_x}) : $signed({1'b0, nd_quo_x});
      ny_d_ff   <= nd_sy ? -$signed({1'b0, nd_quo_y}) : $signed({1'b0, nd_quo_y});
      rvx_d_ff  <= {nd_tag.pair.v1x[COORD_W-1], nd_tag.pair.v1x}
                 - {nd_tag.pair.v2x[COORD_W-1], nd_tag.pair.v2x};
      rvy_d_ff  <= {nd_tag.pair.v1y[COORD_W-1], nd_tag.pair.v1y}
                 - {nd_tag.pair.v2y[COORD_W-1], nd_tag.pair.v2y};
      zero_d_ff <= nd_tag.span == '0;
      dist_d_ff <= nd_tag.span;
   end

   // stage e: projection products
   logic                     valid_e_ff;
   pair_type                 pair_e_ff;
   norm_type                 nx_e_ff, ny_e_ff;
   logic signed [PROD_W-1:0] prx_e_ff, pry_e_ff;
   logic                     zero_e_ff;
   logic [SQ_OUT_W-1:0]      dist_e_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_e_ff <= 1'b0;
      end else begin
         valid_e_ff <= valid_d_ff;
      end
      pair_e_ff <= pair_d_ff;
      nx_e_ff   <= nx_d_ff;
      ny_e_ff   <= ny_d_ff;
      prx_e_ff  <= rvx_d_ff * nx_d_ff;
      pry_e_ff  <= rvy_d_ff * ny_d_ff;
      zero_e_ff <= zero_d_ff;
      dist_e_ff <= dist_d_ff;
   end

   // stage f: normal velocity, overlap
   logic signed [PROD_W:0]   vn_sum;
   logic [RAD_W-1:0]         rsum_e;
   logic                     valid_f_ff;
   pair_type                 pair_f_ff;
   norm_type                 nx_f_ff, ny_f_ff;
   logic signed [VN_W-1:0]   vn_f_ff;
   logic signed [OVL_W-1:0]  overlap_f_ff;
   logic [RAD_W-1:0]         rsum_f_ff;
   logic                     zero_f_ff;

   assign vn_sum = prx_e_ff + pry_e_ff;
   assign rsum_e = RAD_BASE + RAD_BASE + RAD_W'(pair_e_ff.m1) + RAD_W'(pair_e_ff.m2);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_f_ff <= 1'b0;
      end else begin
         valid_f_ff <= valid_e_ff;
      end
      pair_f_ff    <= pair_e_ff;
      nx_f_ff      <= nx_e_ff;
      ny_f_ff      <= ny_e_ff;
      vn_f_ff      <= VN_W'(vn_sum >>> NORM_BITS);
      overlap_f_ff <= $signed({{(OVL_W-RAD_W){1'b0}}, rsum_e})
                    - $signed({1'b0, dist_e_ff, 1'b0});
      rsum_f_ff    <= rsum_e;
      zero_f_ff    <= zero_e_ff;
   end

   // stage g: outcome and impulse magnitude
   logic [NEG_VN_W-1:0]       neg_vn;
   logic [ELAST_W+NEG_VN_W:0] s_full;
   logic                      valid_g_ff;
   pair_type                  pair_g_ff;
   norm_type                  nx_g_ff, ny_g_ff;
   logic [1:0]                outcome_g_ff;
   logic [S_W-1:0]            s_g_ff;
   logic                      ov_pos_g_ff;
   logic [RAD_W-1:0]          ov_g_ff;
   logic [RAD_W-1:0]          rsum_g_ff;

   assign neg_vn = NEG_VN_W'(-vn_f_ff);
   assign s_full = ({1'b0, elast_ff} + ELAST_ONE) * neg_vn;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_g_ff <= 1'b0;
      end else begin
         valid_g_ff <= valid_f_ff;
      end
      pair_g_ff <= pair_f_ff;
      nx_g_ff   <= nx_f_ff;
      ny_g_ff   <= ny_f_ff;
      if (zero_f_ff) begin
         outcome_g_ff <= OUTCOME_COINCIDE;
      end else if (!vn_f_ff[VN_W-1] && (|vn_f_ff)) begin
         outcome_g_ff <= OUTCOME_SEPARATE;
      end else begin
         outcome_g_ff <= OUTCOME_IMPULSE;
      end
      s_g_ff      <= s_full[S_W-1:0];
      ov_pos_g_ff <= !overlap_f_ff[OVL_W-1] && (|overlap_f_ff);
      ov_g_ff     <= overlap_f_ff[RAD_W-1:0];
      rsum_g_ff   <= rsum_f_ff;
   end

   // stage h: dividends
   logic               valid_h_ff;
   ap_tag_type         ap_tag_h_ff;
   logic [Q_NUM_W-1:0] numq_h_ff;
   logic [MSUM_W-1:0]  msum_h_ff;
   logic [A_NUM_W-1:0] numa_h_ff;
   logic [RAD_W-1:0]   rsum_h_ff;
   logic               mzero_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_h_ff <= 1'b0;
      end else begin
         valid_h_ff <= valid_g_ff;
      end
      ap_tag_h_ff.pair    <= pair_g_ff;
      ap_tag_h_ff.nx      <= nx_g_ff;
      ap_tag_h_ff.ny      <= ny_g_ff;
      ap_tag_h_ff.outcome <= outcome_g_ff;
      ap_tag_h_ff.ov_pos  <= ov_pos_g_ff;
      ap_tag_h_ff.s       <= s_g_ff;
      ap_tag_h_ff.ov      <= ov_g_ff;
      numq_h_ff  <= s_g_ff * pair_g_ff.m2;
      msum_h_ff  <= MSUM_W'(pair_g_ff.m1) + MSUM_W'(pair_g_ff.m2);
      numa_h_ff  <= ov_g_ff * (RAD_BASE + RAD_W'(pair_g_ff.m1));
      rsum_h_ff  <= rsum_g_ff;
      mzero_h_ff <= (pair_g_ff.m1 == '0) && (pair_g_ff.m2 == '0);
   end

   logic [DIV_Q_W-1:0] dq_quo, da_quo;
   logic               dq_nz, da_nz;
   logic               dq_mzero;
   logic               da_valid;
   ap_tag_type         da_tag;

   ccir_div #(
      .NUM_W (Q_NUM_W),
      .DEN_W (MSUM_W),
      .QUO_W (DIV_Q_W),
      .TAG_W (1)
   ) u_div_q (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (valid_h_ff),
      .in_num     (numq_h_ff),
      .in_den     (msum_h_ff),
      .in_tag     (mzero_h_ff),
      .out_valid  (),
      .out_quo    (dq_quo),
      .out_rem_nz (dq_nz),
      .out_tag    (dq_mzero)
   );

   ccir_div #(
      .NUM_W (A_NUM_W),
      .DEN_W (RAD_W),
      .QUO_W (DIV_Q_W),
      .TAG_W ($bits(ap_tag_type))
   ) u_div_a (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (valid_h_ff),
      .in_num     (numa_h_ff),
      .in_den     (rsum_h_ff),
      .in_tag     (ap_tag_h_ff),
      .out_valid  (da_valid),
      .out_quo    (da_quo),
      .out_rem_nz (da_nz),
      .out_tag    (da_tag)
   );

   // stage i: shares of impulse and push-out
   logic             valid_i_ff;
   pair_type         pair_i_ff;
   norm_type         nx_i_ff, ny_i_ff;
   logic [1:0]       outcome_i_ff;
   logic [S_W-1:0]   q1_i_ff, q2_i_ff;
   logic [RAD_W-1:0] a1_i_ff, a2_i_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_i_ff <= 1'b0;
      end else begin
         valid_i_ff <= da_valid;
      end
      pair_i_ff    <= da_tag.pair;
      nx_i_ff      <= da_tag.nx;
      ny_i_ff      <= da_tag.ny;
      outcome_i_ff <= da_tag.outcome;
      if (dq_mzero) begin
         q1_i_ff <= '0;
         q2_i_ff <= '0;
      end else begin
         q1_i_ff <= dq_quo;
         q2_i_ff <= da_tag.s - dq_quo - S_W'(dq_nz);
      end
      if (da_tag.ov_pos) begin
         a1_i_ff <= da_quo[RAD_W-1:0];
         a2_i_ff <= da_tag.ov - da_quo[RAD_W-1:0] - RAD_W'(da_nz);
      end else begin
         a1_i_ff <= '0;
         a2_i_ff <= '0;
      end
   end

   // stage j: deltas along the normal
   logic signed [S_W+NORM_W:0]   pv1x, pv1y, pv2x, pv2y;
   logic signed [RAD_W+NORM_W:0] pc1x, pc1y, pc2x, pc2y;

   assign pv1x = $signed({1'b0, q1_i_ff}) * nx_i_ff;
   assign pv1y = $signed({1'b0, q1_i_ff}) * ny_i_ff;
   assign pv2x = $signed({1'b0, q2_i_ff}) * nx_i_ff;
   assign pv2y = $signed({1'b0, q2_i_ff}) * ny_i_ff;
   assign pc1x = $signed({1'b0, a1_i_ff}) * nx_i_ff;
   assign pc1y = $signed({1'b0, a1_i_ff}) * ny_i_ff;
   assign pc2x = $signed({1'b0, a2_i_ff}) * nx_i_ff;
   assign pc2y = $signed({1'b0, a2_i_ff}) * ny_i_ff;

   logic                     valid_j_ff;
   pair_type                 pair_j_ff;
   logic [1:0]               outcome_j_ff;
   logic signed [DV_W-1:0]   dv1x_j_ff, dv1y_j_ff, dv2x_j_ff, dv2y_j_ff;
   logic signed [CORR_W-1:0] c1x_j_ff, c1y_j_ff, c2x_j_ff, c2y_j_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_j_ff <= 1'b0;
      end else begin
         valid_j_ff <= valid_i_ff;
      end
      pair_j_ff    <= pair_i_ff;
      outcome_j_ff <= outcome_i_ff;
      dv1x_j_ff    <= DV_W'(pv1x >>> DV_SHIFT);
      dv1y_j_ff    <= DV_W'(pv1y >>> DV_SHIFT);
      dv2x_j_ff    <= DV_W'(pv2x >>> DV_SHIFT);
      dv2y_j_ff    <= DV_W'(pv2y >>> DV_SHIFT);
      c1x_j_ff     <= CORR_W'(pc1x >>> CORR_SHIFT);
      c1y_j_ff     <= CORR_W'(pc1y >>> CORR_SHIFT);
      c2x_j_ff     <= CORR_W'(pc2x >>> CORR_SHIFT);
      c2y_j_ff     <= CORR_W'(pc2y >>> CORR_SHIFT);
   end

   // stage k: apply and saturate on impulse, else pass the inputs through
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= valid_j_ff;
      end
      rsp_outcome <= outcome_j_ff;
      if (outcome_j_ff == OUTCOME_IMPULSE) begin
         rsp_new_first_pos_x  <= sat_coord(SUM_W'(pair_j_ff.p1x) + SUM_W'(c1x_j_ff));
         rsp_new_first_pos_y  <= sat_coord(SUM_W'(pair_j_ff.p1y) + SUM_W'(c1y_j_ff));
         rsp_new_first_vel_x  <= sat_coord(SUM_W'(pair_j_ff.v1x) + SUM_W'(dv1x_j_ff));
         rsp_new_first_vel_y  <= sat_coord(SUM_W'(pair_j_ff.v1y) + SUM_W'(dv1y_j_ff));
         rsp_new_second_pos_x <= sat_coord(SUM_W'(pair_j_ff.p2x) - SUM_W'(c2x_j_ff));
         rsp_new_second_pos_y <= sat_coord(SUM_W'(pair_j_ff.p2y) - SUM_W'(c2y_j_ff));
         rsp_new_second_vel_x <= sat_coord(SUM_W'(pair_j_ff.v2x) - SUM_W'(dv2x_j_ff));
         rsp_new_second_vel_y <= sat_coord(SUM_W'(pair_j_ff.v2y) - SUM_W'(dv2y_j_ff));
      end else begin
         rsp_new_first_pos_x  <= pair_j_ff.p1x;
         rsp_new_first_pos_y  <= pair_j_ff.p1y;
         rsp_new_first_vel_x  <= pair_j_ff.v1x;
         rsp_new_first_vel_y  <= pair_j_ff.v1y;
         rsp_new_second_pos_x <= pair_j_ff.p2x;
         rsp_new_second_pos_y <= pair_j_ff.p2y;
         rsp_new_second_vel_x <= pair_j_ff.v2x;
         rsp_new_second_vel_y <= pair_j_ff.v2y;
      end
   end

endmodule

`default_nettype wire

/* hdl/ccir_sqrt.sv */
`default_nettype none

module ccir_sqrt
   import ccir_pkg::*;
#(
   parameter int TAG_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [SQ_IN_W-1:0]  in_value,
   input  logic [TAG_W-1:0]    in_tag,
   output logic                out_valid,
   output logic [SQ_OUT_W-1:0] out_root,
   output logic [TAG_W-1:0]    out_tag
);

   logic                valid_ff [SQ_OUT_W];
   logic [SQ_REM_W-1:0] rem_ff   [SQ_OUT_W];
   logic [SQ_OUT_W-1:0] root_ff  [SQ_OUT_W];
   logic [SQ_IN_W-1:0]  val_ff   [SQ_OUT_W];
   logic [TAG_W-1:0]    tag_ff   [SQ_OUT_W];

   genvar k;
   for (k = 0; k < SQ_OUT_W; k++) begin : g_step
      logic                valid_cur;
      logic [SQ_REM_W-1:0] rem_cur;
      logic [SQ_OUT_W-1:0] root_cur;
      logic [SQ_IN_W-1:0]  val_cur;
      logic [TAG_W-1:0]    tag_cur;
      logic [SQ_REM_W+1:0] acc;
      logic [SQ_REM_W+1:0] trial;
      logic                ge;
      logic [SQ_REM_W-1:0] rem_in;
      logic [SQ_OUT_W-1:0] root_in;

      if (k == 0) begin : g_first
         assign valid_cur = in_valid;
         assign rem_cur   = '0;
         assign root_cur  = '0;
         assign val_cur   = in_value;
         assign tag_cur   = in_tag;
      end else begin : g_next
         assign valid_cur = valid_ff[k-1];
         assign rem_cur   = rem_ff[k-1];
         assign root_cur  = root_ff[k-1];
         assign val_cur   = val_ff[k-1];
         assign tag_cur   = tag_ff[k-1];
      end

      assign acc     = {rem_cur, val_cur[SQ_IN_W-1 -: 2]};
      assign trial   = (SQ_REM_W+2)'({root_cur, 2'b01});
      assign ge      = acc >= trial;
      assign rem_in  = ge ? SQ_REM_W'(acc - trial) : SQ_REM_W'(acc);
      assign root_in = {root_cur[SQ_OUT_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_cur;
         end
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         val_ff[k]  <= {val_cur[SQ_IN_W-3:0], 2'b00};
         tag_ff[k]  <= tag_cur;
      end
   end

   assign out_valid = valid_ff[SQ_OUT_W-1];
   assign out_root  = root_ff[SQ_OUT_W-1];
   assign out_tag   = tag_ff[SQ_OUT_W-1];

endmodule

`default_nettype wire

/* hdl/ccir_div.sv */
`default_nettype none

module ccir_div #(
   parameter int NUM_W = 41,
   parameter int DEN_W = 25,
   parameter int QUO_W = 17,
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [QUO_W-1:0] out_quo,
   output logic             out_rem_nz,
   output logic [TAG_W-1:0] out_tag
);

   logic             valid_ff [QUO_W];
   logic [DEN_W-1:0] rem_ff   [QUO_W];
   logic [DEN_W-1:0] den_ff   [QUO_W];
   logic [QUO_W-1:0] bits_ff  [QUO_W];
   logic [TAG_W-1:0] tag_ff   [QUO_W];

   genvar k;
   for (k = 0; k < QUO_W; k++) begin : g_step
      logic             valid_cur;
      logic [DEN_W-1:0] rem_cur;
      logic [DEN_W-1:0] den_cur;
      logic [QUO_W-1:0] bits_cur;
      logic [TAG_W-1:0] tag_cur;
      logic [DEN_W:0]   trial;
      logic             ge;
      logic [DEN_W-1:0] rem_in;

      if (k == 0) begin : g_first
         assign valid_cur = in_valid;
         assign rem_cur   = DEN_W'(in_num >> QUO_W);
         assign den_cur   = in_den;
         assign bits_cur  = in_num[QUO_W-1:0];
         assign tag_cur   = in_tag;
      end else begin : g_next
         assign valid_cur = valid_ff[k-1];
         assign rem_cur   = rem_ff[k-1];
         assign den_cur   = den_ff[k-1];
         assign bits_cur  = bits_ff[k-1];
         assign tag_cur   = tag_ff[k-1];
      end

      assign trial  = {rem_cur, bits_cur[QUO_W-1]};
      assign ge     = trial >= {1'b0, den_cur};
      assign rem_in = ge ? DEN_W'(trial - {1'b0, den_cur}) : trial[DEN_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_cur;
         end
         rem_ff[k]  <= rem_in;
         den_ff[k]  <= den_cur;
         bits_ff[k] <= {bits_cur[QUO_W-2:0], ge};
         tag_ff[k]  <= tag_cur;
      end
   end

   assign out_valid  = valid_ff[QUO_W-1];
   assign out_quo    = bits_ff[QUO_W-1];
   assign out_rem_nz = |rem_ff[QUO_W-1];
   assign out_tag    = tag_ff[QUO_W-1];

endmodule

`default_nettype wire

/* tb/circle_collision_impulse_resolve_top_tb.sv */
`default_nettype none

module circle_collision_impulse_resolve_top_tb;
   import ccir_pkg::*;

   localparam int LATENCY = 88;

   typedef struct {
      logic signed [COORD_W-1:0] p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y;
      logic [MASS_W-1:0] m1, m2;
      logic [ELAST_W-1:0] elast;
      bit cfg_write;
   } pair_item_t;

   typedef struct {
      logic signed [COORD_W-1:0] p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y;
      logic [1:0] outcome;
   } resolved_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic csr_wr_en = 1'b0;
   logic [ELAST_W-1:0] csr_wr_data = '0;
   logic signed [COORD_W-1:0] req_first_pos_x = '0, req_first_pos_y = '0;
   logic signed [COORD_W-1:0] req_first_vel_x = '0, req_first_vel_y = '0;
   logic [MASS_W-1:0] req_first_mass = '0;
   logic signed [COORD_W-1:0] req_second_pos_x = '0, req_second_pos_y = '0;
   logic signed [COORD_W-1:0] req_second_vel_x = '0, req_second_vel_y = '0;
   logic [MASS_W-1:0] req_second_mass = '0;
   logic rsp_strobe;
   logic signed [COORD_W-1:0] rsp_new_first_pos_x, rsp_new_first_pos_y;
   logic signed [COORD_W-1:0] rsp_new_first_vel_x, rsp_new_first_vel_y;
   logic signed [COORD_W-1:0] rsp_new_second_pos_x, rsp_new_second_pos_y;
   logic signed [COORD_W-1:0] rsp_new_second_vel_x, rsp_new_second_vel_y;
   logic [1:0] rsp_outcome;

   circle_collision_impulse_resolve_top u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_first_pos_x(req_first_pos_x), .req_first_pos_y(req_first_pos_y),
      .req_first_vel_x(req_first_vel_x), .req_first_vel_y(req_first_vel_y),
      .req_first_mass(req_first_mass),
      .req_second_pos_x(req_second_pos_x), .req_second_pos_y(req_second_pos_y),
      .req_second_vel_x(req_second_vel_x), .req_second_vel_y(req_second_vel_y),
      .req_second_mass(req_second_mass),
      .rsp_strobe(rsp_strobe),
      .rsp_new_first_pos_x(rsp_new_first_pos_x), .rsp_new_first_pos_y(rsp_new_first_pos_y),
      .rsp_new_first_vel_x(rsp_new_first_vel_x), .rsp_new_first_vel_y(rsp_new_first_vel_y),
      .rsp_new_second_pos_x(rsp_new_second_pos_x),
      .rsp_new_second_pos_y(rsp_new_second_pos_y),
      .rsp_new_second_vel_x(rsp_new_second_vel_x),
      .rsp_new_second_vel_y(rsp_new_second_vel_y),
      .rsp_outcome(rsp_outcome)
   );

   pair_item_t pending_pairs[$];
   resolved_t  expected_results[$];
   logic [ELAST_W-1:0] restitution = ELAST_RESET;
   int errors = 0;
   int pairs_sent = 0;
   int results_seen = 0;
   int impulse_count = 0;
   int separate_count = 0;
   int coincide_count = 0;
   int burst_left = 0;
   int gap_left = 0;
   bit stim_done = 1'b0;
   bit cfg_waiting = 1'b0;
   int drain_wait = 0;
   int cycle_count = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint floor_sh(longint v, int k);
      if (v >= 0) return v >>> k;
      return -((-v + ((longint'(1) << k) - 1)) >>> k);
   endfunction

   function automatic longint int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = longint'(1) << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic signed [COORD_W-1:0] clamp24(longint v);
      if (v > 8388607) return 24'sh7FFFFF;
      if (v < -8388608) return 24'sh800000;
      return v[COORD_W-1:0];
   endfunction

   function automatic resolved_t resolve_pair(pair_item_t it, logic [ELAST_W-1:0] e);
      resolved_t r;
      longint p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y, m1, m2, dx, dy;
      longint span, nx, ny, vn, s, msum, q1, q2, r1, r2, rsum, ovl, a1, a2;
      p1x = it.p1x; p1y = it.p1y; v1x = it.v1x; v1y = it.v1y;
      p2x = it.p2x; p2y = it.p2y; v2x = it.v2x; v2y = it.v2y;
      m1 = it.m1; m2 = it.m2;
      dx = p1x - p2x;
      dy = p1y - p2y;
      if (dx == 0 && dy == 0) begin
         r.outcome = OUTCOME_COINCIDE;
      end else begin
         span = int_sqrt(dx * dx + dy * dy);
         nx = (dx * 65536) / span;
         ny = (dy * 65536) / span;
         vn = floor_sh((v1x - v2x) * nx + (v1y - v2y) * ny, NORM_BITS);
         if (vn > 0) begin
            r.outcome = OUTCOME_SEPARATE;
         end else begin
            r.outcome = OUTCOME_IMPULSE;
            s = (256 + longint'(e)) * (-vn);
            msum = m1 + m2;
            q1 = 0;
            q2 = 0;
            r1 = (5 << 9) + m1;
            r2 = (5 << 9) + m2;
            rsum = r1 + r2;
            ovl = rsum - 2 * span;
            if (msum != 0) begin
               q1 = (s * m2) / msum;
               q2 = (s * m1) / msum;
            end
            v1x += floor_sh(q1 * nx, DV_SHIFT);
            v1y += floor_sh(q1 * ny, DV_SHIFT);
            v2x -= floor_sh(q2 * nx, DV_SHIFT);
            v2y -= floor_sh(q2 * ny, DV_SHIFT);
            if (ovl > 0) begin
               a1 = (ovl * r1) / rsum;
               a2 = (ovl * r2) / rsum;
               p1x += floor_sh(a1 * nx, CORR_SHIFT);
               p1y += floor_sh(a1 * ny, CORR_SHIFT);
               p2x -= floor_sh(a2 * nx, CORR_SHIFT);
               p2y -= floor_sh(a2 * ny, CORR_SHIFT);
            end
         end
      end
      r.p1x = clamp24(p1x); r.p1y = clamp24(p1y);
      r.v1x = clamp24(v1x); r.v1y = clamp24(v1y);
      r.p2x = clamp24(p2x); r.p2y = clamp24(p2y);
      r.v2x = clamp24(v2x); r.v2y = clamp24(v2y);
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      errors++;
      $display("mismatch on result %0d: %s got %0d want %0d", results_seen, what, got, want);
   endtask

   function automatic logic signed [COORD_W-1:0] rand_coord(int mode);
      case (mode)
         0: return 24'($urandom);
         1: return $signed(24'($urandom_range(0, 8000))) - 24'sd4000;
         default: return $signed(24'($urandom_range(0, 2000000))) - 24'sd1000000;
      endcase
   endfunction

   function automatic pair_item_t make_pair(int kind);
      pair_item_t it;
      logic signed [COORD_W-1:0] cx, cy;
      int mode;
      it.cfg_write = 1'b0;
      it.elast = '0;
      mode = $urandom_range(0, 2);
      it.m1 = (kind == 3) ? 16'($urandom) : 16'($urandom_range(1, 65535));
      it.m2 = (kind == 3) ? 16'($urandom) : 16'($urandom_range(1, 65535));
      it.v1x = rand_coord(mode); it.v1y = rand_coord(mode);
      it.v2x = rand_coord(mode); it.v2y = rand_coord(mode);
      if (kind == 0) begin
         it.p1x = rand_coord(0); it.p1y = rand_coord(0);
         it.p2x = rand_coord(0); it.p2y = rand_coord(0);
      end else begin
         cx = rand_coord(2);
         cy = rand_coord(2);
         it.p1x = cx + rand_coord(1); it.p1y = cy + rand_coord(1);
         it.p2x = cx + rand_coord(1); it.p2y = cy + rand_coord(1);
         if (kind == 2) begin
            it.p2x = it.p1x;
            it.p2y = it.p1y;
         end
      end
      return it;
   endfunction

   function automatic pair_item_t cfg_marker(logic [ELAST_W-1:0] v);
      pair_item_t it;
      it = make_pair(1);
      it.cfg_write = 1'b1;
      it.elast = v;
      return it;
   endfunction

   function automatic pair_item_t directed(longint a, longint b, longint c, longint d,
                                           longint m1, longint m2);
      pair_item_t it;
      it.cfg_write = 1'b0;
      it.elast = '0;
      it.p1x = COORD_W'(a); it.p1y = '0; it.v1x = COORD_W'(c); it.v1y = '0;
      it.m1 = MASS_W'(m1);
      it.p2x = COORD_W'(b); it.p2y = '0; it.v2x = COORD_W'(d); it.v2y = '0;
      it.m2 = MASS_W'(m2);
      return it;
   endfunction

   initial begin
      pair_item_t it;
      logic [ELAST_W-1:0] settings[6];
      int k;
      settings = '{9'd0, 9'd256, 9'd511, 9'd128, 9'd1, 9'd205};
      pending_pairs.push_back(directed(0, 0, 100, -100, 256, 256));
      pending_pairs.push_back(directed(1000, 0, 100, -100, 256, 256));
      pending_pairs.push_back(directed(0, 1000, -100, 100, 256, 256));
      pending_pairs.push_back(directed(1000, 0, -500, 500, 256, 512));
      pending_pairs.push_back(directed(100000, 0, -500, 500, 256, 512));
      pending_pairs.push_back(directed(1000, 0, -500, 500, 0, 0));
      pending_pairs.push_back(directed(1000, 0, -500, 500, 0, 700));
      pending_pairs.push_back(directed(1000, 0, -500, 500, 65535, 65535));
      pending_pairs.push_back(directed(8388607, -8388608, -8388608, 8388607, 65535, 1));
      pending_pairs.push_back(directed(-8388608, 8388607, 8388607, -8388608, 1, 65535));
      pending_pairs.push_back(directed(8388607, 8388600, -8388608, 8388607, 65535, 65535));
      pending_pairs.push_back(directed(-8388608, -8388600, 8388607, -8388608, 65535, 65535));
      pending_pairs.push_back(directed(1, 0, -1, 0, 1, 1));
      it = directed(3000, -3000, -8388608, 8388607, 40000, 300);
      it.p1y = 24'sd2500; it.p2y = -24'sd2500; it.v1y = 24'sh7FFFFF; it.v2y = 24'sh800000;
      pending_pairs.push_back(it);
      it.p1y = 24'sh800000; it.p2y = 24'sh7FFFFF;
      pending_pairs.push_back(it);
      for (int s = 0; s < 6; s++) begin
         pending_pairs.push_back(cfg_marker(settings[s]));
         for (int n = 0; n < 225; n++) begin
            k = $urandom_range(0, 19);
            pending_pairs.push_back(make_pair(k < 2 ? 0 : (k < 3 ? 2 : (k < 5 ? 3 : 1))));
         end
      end
   end

   always @(posedge clock) begin
      pair_item_t it;
      bit cfg_fire;
      cfg_fire = 1'b0;
      if (cycle_count == 6) reset <= 1'b0;
      if (!reset) begin
         if (start && !busy) begin
            expected_results.push_back(resolve_pair(pending_pairs.pop_front(), restitution));
            pairs_sent++;
         end
         if (cfg_waiting) begin
            start <= 1'b0;
            if (expected_results.size() == 0 && !(start && !busy)) begin
               if (drain_wait < LATENCY + 4) begin
                  drain_wait++;
               end else begin
                  it = pending_pairs.pop_front();
                  cfg_fire = 1'b1;
                  csr_wr_data <= it.elast;
                  restitution = it.elast;
                  cfg_waiting = 1'b0;
               end
            end
         end else if (pending_pairs.size() == 0 || (start && !busy &&
                      pending_pairs.size() == 0)) begin
            start <= 1'b0;
            stim_done = 1'b1;
         end else if (pending_pairs[0].cfg_write) begin
            start <= 1'b0;
            cfg_waiting = 1'b1;
            drain_wait = 0;
         end else if (start && busy) begin
            start <= 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
            end
            burst_left--;
            if (burst_left == 0) begin
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end
            start <= 1'b1;
            it = pending_pairs[0];
            req_first_pos_x <= it.p1x; req_first_pos_y <= it.p1y;
            req_first_vel_x <= it.v1x; req_first_vel_y <= it.v1y;
            req_first_mass <= it.m1;
            req_second_pos_x <= it.p2x; req_second_pos_y <= it.p2y;
            req_second_vel_x <= it.v2x; req_second_vel_y <= it.v2y;
            req_second_mass <= it.m2;
         end
      end
      csr_wr_en <= cfg_fire;
   end

   always @(posedge clock) begin
      resolved_t want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_strobe) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result strobe", 1, 0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_new_first_pos_x !== want.p1x)
               report_mismatch("new_first_pos_x", rsp_new_first_pos_x, want.p1x);
            if (rsp_new_first_pos_y !== want.p1y)
               report_mismatch("new_first_pos_y", rsp_new_first_pos_y, want.p1y);
            if (rsp_new_first_vel_x !== want.v1x)
               report_mismatch("new_first_vel_x", rsp_new_first_vel_x, want.v1x);
            if (rsp_new_first_vel_y !== want.v1y)
               report_mismatch("new_first_vel_y", rsp_new_first_vel_y, want.v1y);
            if (rsp_new_second_pos_x !== want.p2x)
               report_mismatch("new_second_pos_x", rsp_new_second_pos_x, want.p2x);
            if (rsp_new_second_pos_y !== want.p2y)
               report_mismatch("new_second_pos_y", rsp_new_second_pos_y, want.p2y);
            if (rsp_new_second_vel_x !== want.v2x)
               report_mismatch("new_second_vel_x", rsp_new_second_vel_x, want.v2x);
            if (rsp_new_second_vel_y !== want.v2y)
               report_mismatch("new_second_vel_y", rsp_new_second_vel_y, want.v2y);
            if (rsp_outcome !== want.outcome)
               report_mismatch("outcome", rsp_outcome, want.outcome);
            case (want.outcome)
               OUTCOME_COINCIDE: coincide_count++;
               OUTCOME_SEPARATE: separate_count++;
               default: impulse_count++;
            endcase
         end
      end
   end

   initial begin
      int tail;
      wait (stim_done);
      tail = 0;
      while (expected_results.size() != 0 || tail < LATENCY + 10) begin
         @(posedge clock);
         if (expected_results.size() == 0) tail++;
      end
      $display("%0d pairs transferred, %0d results checked", pairs_sent, results_seen);
      $display("outcomes: %0d coincide, %0d separating, %0d impulse, six restitution settings",
               coincide_count, separate_count, impulse_count);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire

/* sim.f */
hdl/ccir_pkg.sv
hdl/ccir_sqrt.sv
hdl/ccir_div.sv
hdl/circle_collision_impulse_resolve_top.sv
tb/circle_collision_impulse_resolve_top_tb.sv
